// ----- rtl/core/calendar_date_adder_core_defines.svh -----
// Assertion macros shared by the date adder core.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CALENDAR_DATE_ADDER_CORE_DEFINES_SVH
`define CALENDAR_DATE_ADDER_CORE_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the trigger.
`define CDA_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cda assertion failed");

// The consequent must hold in the cycle after the trigger.
`define CDA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cda assertion failed");

`else

`define CDA_ASSERT_NOW(lbl, pre, post)
`define CDA_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ----- rtl/core/cda_pkg.sv -----
package cda_pkg;

  // Field widths of the item ports.
  localparam int MODE_W  = 2;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int AMT_W   = 16;

  // Working widths: the year can run past the port range before clamping.
  localparam int YW   = 17;
  localparam int TW   = 18;
  localparam int R4W  = 9;

  localparam int YEAR_MAX = 9999;

  // Reciprocals for the constant divisions by 400 and by 12.
  localparam int RECIP400_W = 18;
  localparam logic [RECIP400_W-1:0] RECIP400 = 18'd167773;
  localparam int SH400 = 26;
  localparam int RECIP12_W = 19;
  localparam logic [RECIP12_W-1:0] RECIP12 = 19'd349526;
  localparam int SH12 = 22;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_DAYS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MONTHS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_YEARS  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_QUOT,
    OP_REM,
    OP_YADD,
    OP_FEB29,
    OP_MTOT,
    OP_MQUOT,
    OP_MREM,
    OP_MFIX,
    OP_DCLAMP,
    OP_DSTEP,
    OP_FINISH
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_DAY,
    C_MONTH,
    C_SKIP,
    C_NNZ
  } cond_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } cword_t;

  // Program entry points.
  localparam pc_t A_MONTH = 5'd9;
  localparam pc_t A_DAY   = 5'd15;
  localparam pc_t A_LOOP  = 5'd16;
  localparam pc_t A_DONE  = 5'd17;

  typedef struct packed {
    logic load;
    op_t  op;
  } cda_ctrl_t;

  typedef struct packed {
    logic              n_zero;
    logic [MODE_W-1:0] mode;
  } cda_stat_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YW-1:0]      year;
  } cda_date_t;

  // Microprogram. A true condition loads the target, otherwise the step advances.
  function automatic cword_t ucode(input pc_t pc);
    cword_t w;
    w = '{op: OP_NOP, cond: C_NONE, target: '0};
    unique case (pc)
      5'd0:  w = '{op: OP_QUOT,   cond: C_NONE,   target: '0};
      5'd1:  w = '{op: OP_REM,    cond: C_NONE,   target: '0};
      5'd2:  w = '{op: OP_NOP,    cond: C_DAY,    target: A_DAY};
      5'd3:  w = '{op: OP_NOP,    cond: C_SKIP,   target: A_DONE};
      5'd4:  w = '{op: OP_NOP,    cond: C_MONTH,  target: A_MONTH};
      5'd5:  w = '{op: OP_YADD,   cond: C_NONE,   target: '0};
      5'd6:  w = '{op: OP_QUOT,   cond: C_NONE,   target: '0};
      5'd7:  w = '{op: OP_REM,    cond: C_NONE,   target: '0};
      5'd8:  w = '{op: OP_FEB29,  cond: C_ALWAYS, target: A_DONE};
      5'd9:  w = '{op: OP_MTOT,   cond: C_NONE,   target: '0};
      5'd10: w = '{op: OP_MQUOT,  cond: C_NONE,   target: '0};
      5'd11: w = '{op: OP_MREM,   cond: C_NONE,   target: '0};
      5'd12: w = '{op: OP_QUOT,   cond: C_NONE,   target: '0};
      5'd13: w = '{op: OP_REM,    cond: C_NONE,   target: '0};
      5'd14: w = '{op: OP_MFIX,   cond: C_ALWAYS, target: A_DONE};
      5'd15: w = '{op: OP_DCLAMP, cond: C_NONE,   target: '0};
      5'd16: w = '{op: OP_DSTEP,  cond: C_NNZ,    target: A_LOOP};
      5'd17: w = '{op: OP_FINISH, cond: C_NONE,   target: '0};
      default: w = '{op: OP_FINISH, cond: C_NONE, target: '0};
    endcase
    return w;
  endfunction

  // Leap year from the year modulo 400.
  function automatic logic leap_of(input logic [R4W-1:0] r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/cda_datapath.sv -----
module cda_datapath (
  input  logic                              clk,
  input  cda_pkg::cda_ctrl_t                ctrl,
  input  logic [cda_pkg::MODE_W-1:0]        ld_mode,
  input  logic [cda_pkg::DAY_W-1:0]         ld_day,
  input  logic [cda_pkg::MONTH_W-1:0]       ld_month,
  input  logic [cda_pkg::YEAR_W-1:0]        ld_year,
  input  logic [cda_pkg::AMT_W-1:0]         ld_amount,
  output cda_pkg::cda_stat_t                stat,
  output cda_pkg::cda_date_t                date
);
  import cda_pkg::*;

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [DAY_W-1:0]   d_r, d_nxt;
  logic [MONTH_W-1:0] m_r, m_nxt;
  logic [YW-1:0]      y_r, y_nxt;
  logic [AMT_W-1:0]   n_r, n_nxt;
  logic [TW-1:0]      t_r, t_nxt;
  logic [R4W-1:0]     q_r, q_nxt;
  logic [R4W-1:0]     r400_r, r400_nxt;

  logic                                  leap;
  logic [DAY_W-1:0]                      mlen;
  logic [YW-1:0]                         y_plus;
  logic [R4W-1:0]                        r_plus;
  logic [8:0]                            ylen;
  logic [5:0]                            rest;
  logic [YW+RECIP400_W-1:0]              prod400;
  logic [TW+RECIP12_W-1:0]               prod12;
  logic [TW-1:0]                         y12;
  logic [TW-1:0]                         mrem;
  logic [YW-1:0]                         q400;

  // Shared arithmetic terms.
  assign leap    = leap_of(r400_r);
  assign mlen    = month_len(m_r, leap);
  assign y_plus  = y_r + 17'd1;
  assign r_plus  = (r400_r == 9'd399) ? 9'd0 : r400_r + 9'd1;
  assign ylen    = leap ? 9'd366 : 9'd365;
  assign rest    = 6'(mlen) - 6'(d_r) + 6'd1;
  assign prod400 = (YW+RECIP400_W)'(y_r) * (YW+RECIP400_W)'(RECIP400);
  assign prod12  = (TW+RECIP12_W)'(t_r) * (TW+RECIP12_W)'(RECIP12);
  assign y12     = TW'(y_r) * 18'd12;
  assign mrem    = t_r - y12;
  assign q400    = YW'(q_r) * 17'd400;

  // Next values for the operation of the current control word.
  always_comb begin
    mode_nxt = mode_r;
    d_nxt    = d_r;
    m_nxt    = m_r;
    y_nxt    = y_r;
    n_nxt    = n_r;
    t_nxt    = t_r;
    q_nxt    = q_r;
    r400_nxt = r400_r;
    if (ctrl.load) begin
      mode_nxt = ld_mode;
      d_nxt    = (ld_day == '0) ? 5'd1 : ld_day;
      m_nxt    = (ld_month == '0) ? 4'd1 : ((ld_month > 4'd12) ? 4'd12 : ld_month);
      y_nxt    = YW'(ld_year);
      n_nxt    = ld_amount;
    end else begin
      unique case (ctrl.op)
        OP_QUOT:  q_nxt = R4W'(prod400 >> SH400);
        OP_REM:   r400_nxt = R4W'(y_r - q400);
        OP_YADD:  y_nxt = y_r + YW'(n_r);
        OP_FEB29: begin
          if (d_r == 5'd29 && m_r == 4'd2 && !leap) begin
            d_nxt = 5'd1;
            m_nxt = 4'd3;
          end
        end
        OP_MTOT:  t_nxt = y12 + TW'(m_r - 4'd1) + TW'(n_r);
        OP_MQUOT: y_nxt = YW'(prod12 >> SH12);
        OP_MREM:  m_nxt = mrem[MONTH_W-1:0] + 4'd1;
        OP_MFIX: begin
          // A day past the month end rolls into the next month.
          if (d_r > mlen) begin
            d_nxt = d_r - mlen;
            if (m_r == 4'd12) begin
              m_nxt = 4'd1;
              y_nxt = y_plus;
            end else begin
              m_nxt = m_r + 4'd1;
            end
          end
        end
        OP_DCLAMP: begin
          if (d_r > mlen) begin
            d_nxt = mlen;
          end
        end
        OP_DSTEP: begin
          // Hop a whole year from January 1, else finish the month, else add the rest.
          if (d_r == 5'd1 && m_r == 4'd1 && n_r >= AMT_W'(ylen)) begin
            n_nxt    = n_r - AMT_W'(ylen);
            y_nxt    = y_plus;
            r400_nxt = r_plus;
          end else if (n_r >= AMT_W'(rest)) begin
            n_nxt = n_r - AMT_W'(rest);
            d_nxt = 5'd1;
            if (m_r == 4'd12) begin
              m_nxt    = 4'd1;
              y_nxt    = y_plus;
              r400_nxt = r_plus;
            end else begin
              m_nxt = m_r + 4'd1;
            end
          end else begin
            d_nxt = d_r + n_r[DAY_W-1:0];
            n_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    y_r    <= y_nxt;
    n_r    <= n_nxt;
    t_r    <= t_nxt;
    q_r    <= q_nxt;
    r400_r <= r400_nxt;
  end

  assign stat.n_zero = (n_r == '0);
  assign stat.mode   = mode_r;
  assign date.day    = d_r;
  assign date.month  = m_r;
  assign date.year   = y_r;

endmodule

// ----- rtl/core/calendar_date_adder_core.sv -----
// Gregorian date adder: moves a date forward by a number of days, months or years.
// An item is taken at a rising edge with start high and busy low; in_mode picks
// days (0), months (1) or years (2), and mode 3 returns the start date.
// busy stays high from the edge that takes the item until the result is out.
// The result appears on the out_ ports for one cycle, marked by out_valid; the
// receiver cannot stall, so it must capture the item in that cycle.
// A short microprogram in a read-only table steps a shared datapath, one
// control word per cycle. Mode 3, or a zero amount in month or year mode, jumps
// to the final step. Adding years moves February 29 of a non-leap year to
// March 1; adding months rolls a day past the month end into the next month;
// adding days clamps the day to the month length and then runs the day loop,
// which takes one year or month per cycle and adds the remaining days last.
// A year above the maximum is reported as the maximum with out_year_overflow set.
// A new item may start in the cycle that out_valid is high.
// Reset, synchronous and active low, drops busy and out_valid and abandons work.
`include "calendar_date_adder_core_defines.svh"

module calendar_date_adder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cda_pkg::MODE_W-1:0]    in_mode,
  input  logic [cda_pkg::DAY_W-1:0]     in_start_day,
  input  logic [cda_pkg::MONTH_W-1:0]   in_start_month,
  input  logic [cda_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [cda_pkg::AMT_W-1:0]     in_amount,
  output logic                          out_valid,
  output logic [cda_pkg::DAY_W-1:0]     out_new_day,
  output logic [cda_pkg::MONTH_W-1:0]   out_new_month,
  output logic [cda_pkg::YEAR_W-1:0]    out_new_year,
  output logic                          out_year_overflow
);
  import cda_pkg::*;

  logic      busy_r, busy_nxt;
  pc_t       pc_r, pc_nxt;
  logic      valid_r, valid_nxt;
  logic      accept;
  logic      take;
  cword_t    cw;
  cda_ctrl_t ctrl;
  cda_stat_t stat;
  cda_date_t date;

  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic               ovf_r;

  assign accept = start && !busy_r;
  assign cw     = ucode(pc_r);

  // Control word to the datapath; nothing runs while idle.
  assign ctrl.load = accept;
  assign ctrl.op   = busy_r ? cw.op : OP_NOP;

  cda_datapath u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .ld_mode   (in_mode),
    .ld_day    (in_start_day),
    .ld_month  (in_start_month),
    .ld_year   (in_start_year),
    .ld_amount (in_amount),
    .stat      (stat),
    .date      (date)
  );

  // Jump condition of the current step.
  always_comb begin
    unique case (cw.cond)
      C_NONE:   take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_DAY:    take = (stat.mode == MODE_DAYS);
      C_MONTH:  take = (stat.mode == MODE_MONTHS);
      C_SKIP:   take = stat.n_zero || (stat.mode == MODE_NONE);
      C_NNZ:    take = !stat.n_zero;
      default:  take = 1'b0;
    endcase
  end

  // Step counter and busy flag.
  always_comb begin
    pc_nxt    = pc_r;
    busy_nxt  = busy_r;
    valid_nxt = 1'b0;
    if (accept) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cw.op == OP_FINISH) begin
        busy_nxt  = 1'b0;
        valid_nxt = 1'b1;
        pc_nxt    = '0;
      end else if (take) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pc_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pc_r    <= pc_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result register, loaded at the final step with the year limit applied.
  always_ff @(posedge clk) begin
    if (busy_r && cw.op == OP_FINISH) begin
      day_r   <= date.day;
      month_r <= date.month;
      if (date.year > YW'(YEAR_MAX)) begin
        year_r <= YEAR_W'(YEAR_MAX);
        ovf_r  <= 1'b1;
      end else begin
        year_r <= date.year[YEAR_W-1:0];
        ovf_r  <= 1'b0;
      end
    end
  end

  assign busy              = busy_r;
  assign out_valid         = valid_r;
  assign out_new_day       = day_r;
  assign out_new_month     = month_r;
  assign out_new_year      = year_r;
  assign out_year_overflow = ovf_r;

  // An accepted item keeps the sequencer running in the next cycle.
  `CDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result only follows a running item, and the sequencer is then free.
  `CDA_ASSERT_NOW(a_valid_after_busy, out_valid, $past(busy) && !busy || start)
  // The strobe lasts a single cycle.
  `CDA_ASSERT_NEXT(a_valid_pulse, out_valid, !out_valid)
  // An overflowed year is reported as the maximum.
  `CDA_ASSERT_NOW(a_ovf_year, out_valid && out_year_overflow, out_new_year == YEAR_W'(YEAR_MAX))

endmodule
